### rtl/fac_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fac_pkg: shared types and constants of the chunk allocator
// Field widths, action and status codes, controller states and the
// structures that travel along the row of chunk cells.
// ----------------------------------------------------------------------------
package fac_pkg;

    // Buffer size and the fixed field widths that follow from it.
    localparam int BUFFER_BYTES = 1024;
    localparam int SZ_W         = 11;
    localparam int ADR_W        = 10;
    localparam int ACT_W        = 2;
    localparam int IDXO_W       = 4;

    typedef enum logic [ACT_W-1:0] {
        ACT_LOAD   = 2'd0,
        ACT_ALLOC  = 2'd1,
        ACT_REINIT = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOFIT    = 2'd1,
        ST_FULL     = 2'd2,
        ST_OVERFLOW = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WRITE,
        S_SWEEP,
        S_FINISH
    } state_t;

    // Command broadcast from the controller to every cell.
    typedef struct packed {
        logic            load_en;
        logic            clear_en;
        logic            fill_en;
        logic            search_en;
        logic [SZ_W-1:0] amount;
        logic [ADR_W-1:0] base;
        logic [SZ_W-1:0] fill_val;
    } cell_cmd_t;

    // Running result handed from one cell to the next during a sweep.
    // The hi candidate is the first fit at or after the search start,
    // the lo candidate the first fit before it.
    typedef struct packed {
        logic             found_hi;
        logic             found_lo;
        logic [SZ_W-1:0]  sum;
        logic [SZ_W-1:0]  max_all;
        logic [SZ_W-1:0]  max_ex_hi;
        logic [SZ_W-1:0]  max_ex_lo;
        logic [SZ_W-1:0]  tail_hi;
        logic [SZ_W-1:0]  tail_lo;
        logic [SZ_W-1:0]  fill_hi;
        logic [SZ_W-1:0]  fill_lo;
        logic [ADR_W-1:0] addr_hi;
        logic [ADR_W-1:0] addr_lo;
    } token_t;

endpackage : fac_pkg
`default_nettype wire

### rtl/fac_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fac_cell: one chunk cell of the allocator row
// Holds one chunk's capacity, fill level and base address, takes table
// writes from the controller and adds its own view to the sweep token.
// ----------------------------------------------------------------------------
module fac_cell #(
    parameter int CELL_IDX = 0,
    parameter int IDX_W    = 4,
    parameter int CNT_W    = 5
) (
    input  wire                     clk,
    input  fac_pkg::cell_cmd_t      cmd,
    input  wire  [IDX_W-1:0]        wr_idx,
    input  wire  [CNT_W-1:0]        total,
    input  wire  [IDX_W-1:0]        start_pos,
    input  fac_pkg::token_t         tok_in,
    input  wire  [IDX_W-1:0]        hi_idx_in,
    input  wire  [IDX_W-1:0]        lo_idx_in,
    output fac_pkg::token_t         tok_out,
    output logic [IDX_W-1:0]        hi_idx_out,
    output logic [IDX_W-1:0]        lo_idx_out
);
    import fac_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);
    localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(CELL_IDX);

    logic [SZ_W-1:0]  cap_reg;
    logic [SZ_W-1:0]  fill_reg;
    logic [ADR_W-1:0] base_reg;
    token_t           tok_reg;
    token_t           tok_next;
    logic [IDX_W-1:0] hi_idx_reg;
    logic [IDX_W-1:0] hi_idx_next;
    logic [IDX_W-1:0] lo_idx_reg;
    logic [IDX_W-1:0] lo_idx_next;

    logic             active;
    logic             selected;
    logic [SZ_W-1:0]  tail;
    logic [SZ_W-1:0]  tail_act;
    logic             fits;
    logic             in_hi;
    logic             take_hi;
    logic             take_lo;

    assign active   = MY_CNT < total;
    assign selected = wr_idx == MY_IDX;

    // Chunk storage: load writes a fresh chunk, allocation updates the fill
    // level, reinitialization empties every loaded chunk.
    always_ff @(posedge clk)
    begin
        if (cmd.load_en && selected)
        begin
            cap_reg  <= cmd.amount;
            fill_reg <= '0;
            base_reg <= cmd.base;
        end
        else if (cmd.fill_en && selected)
        begin
            fill_reg <= cmd.fill_val;
        end
        else if (cmd.clear_en && active)
        begin
            fill_reg <= '0;
        end
    end

    // Free tail of this chunk and whether the request fits in it.
    assign tail     = cap_reg - fill_reg;
    assign tail_act = active ? tail : '0;
    assign fits     = cmd.search_en && active && (tail >= cmd.amount);
    assign in_hi    = MY_IDX >= start_pos;
    assign take_hi  = fits && in_hi && !tok_in.found_hi;
    assign take_lo  = fits && !in_hi && !tok_in.found_lo;

    // Fold this chunk into the running totals and candidate choice.
    always_comb
    begin
        tok_next     = tok_in;
        hi_idx_next  = hi_idx_in;
        lo_idx_next  = lo_idx_in;
        tok_next.sum = tok_in.sum + tail_act;
        if (tail_act > tok_in.max_all)
        begin
            tok_next.max_all = tail_act;
        end
        if (!take_hi && (tail_act > tok_in.max_ex_hi))
        begin
            tok_next.max_ex_hi = tail_act;
        end
        if (!take_lo && (tail_act > tok_in.max_ex_lo))
        begin
            tok_next.max_ex_lo = tail_act;
        end
        if (take_hi)
        begin
            tok_next.found_hi = 1'b1;
            tok_next.tail_hi  = tail;
            tok_next.fill_hi  = fill_reg + cmd.amount;
            tok_next.addr_hi  = base_reg + fill_reg[ADR_W-1:0];
            hi_idx_next       = MY_IDX;
        end
        if (take_lo)
        begin
            tok_next.found_lo = 1'b1;
            tok_next.tail_lo  = tail;
            tok_next.fill_lo  = fill_reg + cmd.amount;
            tok_next.addr_lo  = base_reg + fill_reg[ADR_W-1:0];
            lo_idx_next       = MY_IDX;
        end
    end

    // Hand the token on to the next cell.
    always_ff @(posedge clk)
    begin
        tok_reg    <= tok_next;
        hi_idx_reg <= hi_idx_next;
        lo_idx_reg <= lo_idx_next;
    end

    assign tok_out    = tok_reg;
    assign hi_idx_out = hi_idx_reg;
    assign lo_idx_out = lo_idx_reg;

endmodule : fac_cell
`default_nettype wire

### rtl/fit_allocator_over_chunks.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fit_allocator_over_chunks: first fit / next fit allocator over chunks
// Controller and a row of chunk cells that sweep the table once per item.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with action and amount while busy is low; the item is taken
//   at that clock edge and busy rises on the next cycle. Action 0 appends a
//   chunk, 1 allocates amount bytes, 2 empties every chunk, 3 only reports.
//   Each item gives exactly one result: done is high for one cycle with
//   status, address, chunk_index, free_total and free_largest valid. The
//   receiver cannot hold results off; a result is simply shown once.
//   The S_WRITE state writes the table, a token then walks the row of
//   MAX_CHUNKS cells one cell per cycle in S_SWEEP, and S_FINISH picks the
//   chunk, updates its fill level and registers the result. A new item can
//   be started in the cycle that done is shown; no item is taken while
//   busy is high, so one item is through before the next is started.
//   fit_mode is written through cfg_we and cfg_wdata: 0 first fit, 1 next
//   fit. The user writes it only while the block is idle; the block itself
//   does not enforce this.
//   Reset empties the chunk table, clears the next fit position and selects
//   first fit; no clearing pass is needed.
// ----------------------------------------------------------------------------
module fit_allocator_over_chunks #(
    parameter int MAX_CHUNKS = 16
) (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            start,
    input  wire  [fac_pkg::ACT_W-1:0]      action,
    input  wire  [fac_pkg::SZ_W-1:0]       amount,
    output logic                           busy,
    output logic                           done,
    output logic [1:0]                     status,
    output logic [fac_pkg::ADR_W-1:0]      address,
    output logic [fac_pkg::IDXO_W-1:0]     chunk_index,
    output logic [fac_pkg::SZ_W-1:0]       free_total,
    output logic [fac_pkg::SZ_W-1:0]       free_largest,
    input  wire                            cfg_we,
    input  wire                            cfg_wdata
);
    import fac_pkg::*;

    localparam int IDX_W = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
    localparam int CNT_W = $clog2(MAX_CHUNKS + 1);
    localparam logic [CNT_W-1:0] TOTAL_MAX = CNT_W'(MAX_CHUNKS);
    localparam logic [IDX_W-1:0] LAST_CELL = IDX_W'(MAX_CHUNKS - 1);
    localparam logic [SZ_W:0]    BUF_LIMIT = (SZ_W + 1)'(BUFFER_BYTES);

    // Control state.
    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] total_reg;
    logic [CNT_W-1:0] total_next;
    logic [SZ_W-1:0]  layout_reg;
    logic [SZ_W-1:0]  layout_next;
    logic [IDX_W-1:0] search_pos_reg;
    logic [IDX_W-1:0] search_pos_next;
    logic             mode_reg;
    logic [IDX_W-1:0] cnt_reg;
    logic [IDX_W-1:0] cnt_next;
    logic             done_reg;
    logic             done_next;

    // Item and result payload.
    action_t          act_reg;
    logic [SZ_W-1:0]  amt_reg;
    status_t          res_status_reg;
    status_t          res_status_next;
    logic [ADR_W-1:0] res_addr_reg;
    logic [ADR_W-1:0] res_addr_next;
    logic [IDX_W-1:0] res_idx_reg;
    logic [IDX_W-1:0] res_idx_next;
    status_t          out_status_reg;
    status_t          out_status_next;
    logic [ADR_W-1:0] out_addr_reg;
    logic [ADR_W-1:0] out_addr_next;
    logic [IDX_W-1:0] out_idx_reg;
    logic [IDX_W-1:0] out_idx_next;
    logic [SZ_W-1:0]  out_total_reg;
    logic [SZ_W-1:0]  out_total_next;
    logic [SZ_W-1:0]  out_max_reg;
    logic [SZ_W-1:0]  out_max_next;

    // Cell row connections.
    cell_cmd_t        cmd;
    logic [IDX_W-1:0] wr_idx;
    logic [IDX_W-1:0] start_pos;
    token_t           tok_chain [MAX_CHUNKS+1];
    logic [IDX_W-1:0] hi_chain  [MAX_CHUNKS+1];
    logic [IDX_W-1:0] lo_chain  [MAX_CHUNKS+1];
    token_t           tok_last;

    // Winner selection at the end of the sweep.
    logic             found;
    logic [SZ_W-1:0]  w_tail;
    logic [SZ_W-1:0]  w_maxex;
    logic [SZ_W-1:0]  w_fill;
    logic [ADR_W-1:0] w_addr;
    logic [IDX_W-1:0] w_idx;
    logic [SZ_W-1:0]  new_tail;
    logic [SZ_W:0]    load_end;
    logic [IDX_W+IDXO_W-1:0] idx_ext;

    assign tok_last  = tok_chain[MAX_CHUNKS];
    assign load_end  = {1'b0, layout_reg} + {1'b0, amt_reg};
    assign start_pos = (mode_reg && (CNT_W'(search_pos_reg) < total_reg))
                       ? search_pos_reg : '0;

    // Next fit prefers the first fit at or after the start, then wraps.
    assign found    = tok_last.found_hi || tok_last.found_lo;
    assign w_tail   = tok_last.found_hi ? tok_last.tail_hi   : tok_last.tail_lo;
    assign w_maxex  = tok_last.found_hi ? tok_last.max_ex_hi : tok_last.max_ex_lo;
    assign w_fill   = tok_last.found_hi ? tok_last.fill_hi   : tok_last.fill_lo;
    assign w_addr   = tok_last.found_hi ? tok_last.addr_hi   : tok_last.addr_lo;
    assign w_idx    = tok_last.found_hi ? hi_chain[MAX_CHUNKS] : lo_chain[MAX_CHUNKS];
    assign new_tail = w_tail - amt_reg;

    // Next state, table commands and result assembly.
    always_comb
    begin
        state_next      = state_reg;
        total_next      = total_reg;
        layout_next     = layout_reg;
        search_pos_next = search_pos_reg;
        cnt_next        = cnt_reg;
        done_next       = 1'b0;
        res_status_next = res_status_reg;
        res_addr_next   = res_addr_reg;
        res_idx_next    = res_idx_reg;
        out_status_next = out_status_reg;
        out_addr_next   = out_addr_reg;
        out_idx_next    = out_idx_reg;
        out_total_next  = out_total_reg;
        out_max_next    = out_max_reg;
        cmd             = '0;
        cmd.amount      = amt_reg;
        cmd.base        = layout_reg[ADR_W-1:0];
        wr_idx          = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_WRITE;
                end
            end

            S_WRITE:
            begin
                res_status_next = ST_OK;
                res_addr_next   = '0;
                res_idx_next    = '0;
                if (act_reg == ACT_LOAD)
                begin
                    if (total_reg == TOTAL_MAX)
                    begin
                        res_status_next = ST_FULL;
                    end
                    else if (load_end > BUF_LIMIT)
                    begin
                        res_status_next = ST_OVERFLOW;
                    end
                    else
                    begin
                        cmd.load_en   = 1'b1;
                        wr_idx        = total_reg[IDX_W-1:0];
                        total_next    = total_reg + 1'b1;
                        layout_next   = load_end[SZ_W-1:0];
                        res_addr_next = layout_reg[ADR_W-1:0];
                        res_idx_next  = total_reg[IDX_W-1:0];
                    end
                end
                else if (act_reg == ACT_REINIT)
                begin
                    cmd.clear_en = 1'b1;
                end
                cnt_next   = '0;
                state_next = S_SWEEP;
            end

            S_SWEEP:
            begin
                cmd.search_en = (act_reg == ACT_ALLOC);
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == LAST_CELL)
                begin
                    state_next = S_FINISH;
                end
            end

            S_FINISH:
            begin
                out_status_next = res_status_reg;
                out_addr_next   = res_addr_reg;
                out_idx_next    = res_idx_reg;
                out_total_next  = tok_last.sum;
                out_max_next    = tok_last.max_all;
                if (act_reg == ACT_ALLOC)
                begin
                    if (found)
                    begin
                        cmd.fill_en     = 1'b1;
                        cmd.fill_val    = w_fill;
                        wr_idx          = w_idx;
                        out_status_next = ST_OK;
                        out_addr_next   = w_addr;
                        out_idx_next    = w_idx;
                        out_total_next  = tok_last.sum - amt_reg;
                        out_max_next    = (w_maxex > new_tail) ? w_maxex : new_tail;
                        if (mode_reg)
                        begin
                            search_pos_next = w_idx;
                        end
                    end
                    else
                    begin
                        out_status_next = ST_NOFIT;
                        out_addr_next   = '0;
                        out_idx_next    = '0;
                    end
                end
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            total_reg      <= '0;
            layout_reg     <= '0;
            search_pos_reg <= '0;
            mode_reg       <= 1'b0;
            cnt_reg        <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            total_reg      <= total_next;
            layout_reg     <= layout_next;
            search_pos_reg <= search_pos_next;
            cnt_reg        <= cnt_next;
            done_reg       <= done_next;
            if (cfg_we)
            begin
                mode_reg <= cfg_wdata;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            act_reg <= action_t'(action);
            amt_reg <= amount;
        end
        res_status_reg <= res_status_next;
        res_addr_reg   <= res_addr_next;
        res_idx_reg    <= res_idx_next;
        out_status_reg <= out_status_next;
        out_addr_reg   <= out_addr_next;
        out_idx_reg    <= out_idx_next;
        out_total_reg  <= out_total_next;
        out_max_reg    <= out_max_next;
    end

    // Row of chunk cells; the token enters empty at the first cell.
    assign tok_chain[0] = '0;
    assign hi_chain[0]  = '0;
    assign lo_chain[0]  = '0;

    for (genvar g = 0; g < MAX_CHUNKS; g++)
    begin : g_cell
        fac_cell #(
            .CELL_IDX (g),
            .IDX_W    (IDX_W),
            .CNT_W    (CNT_W)
        ) u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .wr_idx     (wr_idx),
            .total      (total_reg),
            .start_pos  (start_pos),
            .tok_in     (tok_chain[g]),
            .hi_idx_in  (hi_chain[g]),
            .lo_idx_in  (lo_chain[g]),
            .tok_out    (tok_chain[g+1]),
            .hi_idx_out (hi_chain[g+1]),
            .lo_idx_out (lo_chain[g+1])
        );
    end

    // Outputs.
    assign idx_ext      = {{IDXO_W{1'b0}}, out_idx_reg};
    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign status       = out_status_reg;
    assign address      = out_addr_reg;
    assign chunk_index  = idx_ext[IDXO_W-1:0];
    assign free_total   = out_total_reg;
    assign free_largest = out_max_reg;

endmodule : fit_allocator_over_chunks
`default_nettype wire
